/* hw/rtl/cocq_pkg.sv */
// shared types and constants for the class-ordered command queue
`timescale 1ns / 1ps

package cocq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 8;
   localparam int CLASS_BITS_DEF  = 3;

   localparam int ACTION_BITS = 3;
   localparam int EVENT_BITS  = 2;

   // request action codes
   localparam logic [ACTION_BITS-1:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DISPATCH = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_FLUSH    = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_SUSPEND  = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_RESUME   = 3'd4;

   // response event codes
   localparam logic [EVENT_BITS-1:0] EV_DISPATCH = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_FLUSHED  = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_REJECT   = 2'd2;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic ins;
      logic pop;
   } cocq_op_type;

endpackage

/* hw/rtl/cocq_cell.sv */
// one slot of the sorted shift chain
`timescale 1ns / 1ps

module cocq_cell
   import cocq_pkg::*;
#(
   parameter int TAG_BITS   = TAG_BITS_DEF,
   parameter int CLASS_BITS = CLASS_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cocq_op_type           op,
   input  logic [TAG_BITS-1:0]   new_tag,
   input  logic [CLASS_BITS-1:0] new_cls,
   input  logic                  new_sp,
   input  logic                  prev_valid,
   input  logic                  prev_stay,
   input  logic [TAG_BITS-1:0]   prev_tag,
   input  logic [CLASS_BITS-1:0] prev_cls,
   input  logic                  prev_sp,
   input  logic                  next_valid,
   input  logic [TAG_BITS-1:0]   next_tag,
   input  logic [CLASS_BITS-1:0] next_cls,
   input  logic                  next_sp,
   output logic                  valid,
   output logic [TAG_BITS-1:0]   tag,
   output logic [CLASS_BITS-1:0] cls,
   output logic                  sp,
   output logic                  stay
);

   logic                  valid_ff, valid_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [CLASS_BITS-1:0] cls_ff, cls_in;
   logic                  sp_ff, sp_in;
   logic                  load;

   // a queued job of same or higher class keeps its place ahead of the new one
   assign stay = valid_ff && (cls_ff >= new_cls);

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      cls_in   = cls_ff;
      sp_in    = sp_ff;
      priority if (op.ins && !stay) begin
         load = 1'b1;
         if (prev_stay) begin
            valid_in = 1'b1;
            tag_in   = new_tag;
            cls_in   = new_cls;
            sp_in    = new_sp;
         end else begin
            valid_in = prev_valid;
            tag_in   = prev_tag;
            cls_in   = prev_cls;
            sp_in    = prev_sp;
         end
      end else if (op.pop) begin
         load     = 1'b1;
         valid_in = next_valid;
         tag_in   = next_tag;
         cls_in   = next_cls;
         sp_in    = next_sp;
      end else begin
         load     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         tag_ff <= tag_in;
         cls_ff <= cls_in;
         sp_ff  <= sp_in;
      end
   end

   assign valid = valid_ff;
   assign tag   = tag_ff;
   assign cls   = cls_ff;
   assign sp    = sp_ff;

   // chain stays sorted, highest class towards the head
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && prev_valid) |-> (prev_cls >= cls_ff))
      else $error("cell class above its predecessor");

   // occupied slots form an unbroken run from the head
   a_packed: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> prev_valid)
      else $error("hole in the queue chain");

   // a job ahead of the insertion point is left untouched
   a_stay_holds: assert property (@(posedge clock) disable iff (reset)
      (op.ins && stay) |=> (valid_ff && $stable(tag_ff) && $stable(cls_ff)))
      else $error("staying cell changed on insert");

endmodule

/* hw/rtl/class_ordered_command_queue_top.sv */
// class-ordered command queue: sequencer, output register and cell chain
// sequencing: enqueue inserts the job, or sends a reject response when the queue is full, then
//   dispatches the head if allowed; dispatch and resume go to the dispatch step; flush drains
//   from the head, one job per response transfer; suspend sets the flag and gives no response
// one request at a time: req_tready is high only while the sequencer is idle
// reset: synchronous, clears the queue occupancy, suspend flag and response valid;
//   cell payloads are not cleared
`timescale 1ns / 1ps

module class_ordered_command_queue_top
   import cocq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF,
   parameter int CLASS_BITS  = CLASS_BITS_DEF,
   localparam int REQ_W = ((TAG_BITS + CLASS_BITS + 2 + 7) / 8) * 8,
   localparam int RSP_W = ((TAG_BITS + 1 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // job_tag, job_class, is_special, unit_busy, zero fill
   input  logic [REQ_W-1:0]       req_tdata,
   // action
   input  logic [ACTION_BITS-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_tag, out_special, zero fill
   output logic [RSP_W-1:0]       rsp_tdata,
   // event_res
   output logic [EVENT_BITS-1:0]  rsp_tuser,
   output logic                   rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DISP,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   logic [ACTION_BITS-1:0] act_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic [CLASS_BITS-1:0]  cls_ff;
   logic                   sp_ff;
   logic                   busy_ff;
   logic                   susp_ff, susp_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [EVENT_BITS-1:0]  ev_ff, ev_in;
   logic [TAG_BITS-1:0]    otag_ff, otag_in;
   logic                   osp_ff, osp_in;
   logic                   olast_ff, olast_in;
   logic                   emit;

   cocq_op_type            op;
   logic                   req_xfer;
   logic                   out_free;
   logic                   disp_ok;
   logic                   full;

   logic                   cell_valid [QUEUE_DEPTH];
   logic                   cell_stay  [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]    cell_tag   [QUEUE_DEPTH];
   logic [CLASS_BITS-1:0]  cell_cls   [QUEUE_DEPTH];
   logic                   cell_sp    [QUEUE_DEPTH];

   // cell chain, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                  p_valid, p_stay, p_sp, n_valid, n_sp;
      logic [TAG_BITS-1:0]   p_tag, n_tag;
      logic [CLASS_BITS-1:0] p_cls, n_cls;

      if (i == 0) begin : g_head
         assign p_valid = 1'b1;
         assign p_stay  = 1'b1;
         assign p_tag   = '0;
         assign p_cls   = '1;
         assign p_sp    = 1'b0;
      end else begin : g_body
         assign p_valid = cell_valid[i-1];
         assign p_stay  = cell_stay[i-1];
         assign p_tag   = cell_tag[i-1];
         assign p_cls   = cell_cls[i-1];
         assign p_sp    = cell_sp[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_tag   = '0;
         assign n_cls   = '0;
         assign n_sp    = 1'b0;
      end else begin : g_mid
         assign n_valid = cell_valid[i+1];
         assign n_tag   = cell_tag[i+1];
         assign n_cls   = cell_cls[i+1];
         assign n_sp    = cell_sp[i+1];
      end

      cocq_cell #(
         .TAG_BITS   (TAG_BITS),
         .CLASS_BITS (CLASS_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .new_tag    (tag_ff),
         .new_cls    (cls_ff),
         .new_sp     (sp_ff),
         .prev_valid (p_valid),
         .prev_stay  (p_stay),
         .prev_tag   (p_tag),
         .prev_cls   (p_cls),
         .prev_sp    (p_sp),
         .next_valid (n_valid),
         .next_tag   (n_tag),
         .next_cls   (n_cls),
         .next_sp    (n_sp),
         .valid      (cell_valid[i]),
         .tag        (cell_tag[i]),
         .cls        (cell_cls[i]),
         .sp         (cell_sp[i]),
         .stay       (cell_stay[i])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = cell_valid[QUEUE_DEPTH-1];
   // special jobs get past a suspended queue
   assign disp_ok    = !busy_ff && cell_valid[0] && (!susp_ff || cell_sp[0]);

   always_comb begin
      state_in = state_ff;
      susp_in  = susp_ff;
      op       = '0;
      emit     = 1'b0;
      ev_in    = EV_DISPATCH;
      otag_in  = cell_tag[0];
      osp_in   = cell_sp[0];
      olast_in = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (act_ff)
               ACT_ENQUEUE: begin
                  if (full) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        ev_in    = EV_REJECT;
                        otag_in  = tag_ff;
                        osp_in   = sp_ff;
                        olast_in = !disp_ok;
                        state_in = ST_DISP;
                     end
                  end else begin
                     op.ins   = 1'b1;
                     state_in = ST_DISP;
                  end
               end
               ACT_DISPATCH: state_in = ST_DISP;
               ACT_FLUSH:    state_in = ST_FLUSH;
               ACT_SUSPEND: begin
                  susp_in  = 1'b1;
                  state_in = ST_IDLE;
               end
               ACT_RESUME: begin
                  susp_in  = 1'b0;
                  state_in = ST_DISP;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DISP: begin
            if (!disp_ok) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit     = 1'b1;
               op.pop   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            // drain from the head, one transfer per cycle while the response side is free
            if (!cell_valid[0]) begin
               susp_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit     = 1'b1;
               ev_in    = EV_FLUSHED;
               olast_in = !cell_valid[1];
               op.pop   = 1'b1;
               if (!cell_valid[1]) begin
                  susp_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         susp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         susp_ff      <= susp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         act_ff  <= req_tuser;
         tag_ff  <= req_tdata[TAG_BITS-1:0];
         cls_ff  <= req_tdata[TAG_BITS +: CLASS_BITS];
         sp_ff   <= req_tdata[TAG_BITS+CLASS_BITS];
         busy_ff <= req_tdata[TAG_BITS+CLASS_BITS+1];
      end
      if (emit) begin
         ev_ff    <= ev_in;
         otag_ff  <= otag_in;
         osp_ff   <= osp_in;
         olast_ff <= olast_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ev_ff;
   assign rsp_tlast  = olast_ff;

   always_comb begin
      rsp_tdata                 = '0;
      rsp_tdata[TAG_BITS-1:0]   = otag_ff;
      rsp_tdata[TAG_BITS]       = osp_ff;
   end

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != ST_IDLE))
      else $error("response raised while sequencer idle");

   a_op_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({op.ins, op.pop}))
      else $error("insert and pop in the same cycle");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && !cell_valid[0]) |=> !susp_ff)
      else $error("suspend left set after flush");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      op.ins |-> !full)
      else $error("insert into a full queue");

endmodule

/* test/tb_top.sv */
// testbench for the class-ordered command queue: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module tb_top;
   import cocq_pkg::*;

   localparam int QDEPTH = QUEUE_DEPTH_DEF;
   localparam int TAG_W  = TAG_BITS_DEF;
   localparam int CLS_W  = CLASS_BITS_DEF;
   localparam int REQ_W  = ((TAG_W + CLS_W + 2 + 7) / 8) * 8;
   localparam int RSP_W  = ((TAG_W + 1 + 7) / 8) * 8;

   // action codes the block has no use for
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_A = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_B = 3'd6;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_C = 3'd7;

   typedef struct {
      logic [EVENT_BITS-1:0] ev;
      logic [TAG_W-1:0]      tag;
      logic                  sp;
      logic                  is_last;
   } job_event_type;

   typedef struct {
      logic [ACTION_BITS-1:0] act;
      logic [TAG_W-1:0]       tag;
      logic [CLS_W-1:0]       cls;
      logic                   sp;
      logic                   busy;
      int                     reps;
      bit                     typed;
      int                     n_typed;
      job_event_type          rsp;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [ACTION_BITS-1:0] req_tuser = ACT_DISPATCH;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [EVENT_BITS-1:0] rsp_tuser;
   logic rsp_tlast;

   class_ordered_command_queue_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // queue contents as the block should hold them, slot 0 is the head
   logic [TAG_W-1:0] q_tag [QDEPTH];
   logic [CLS_W-1:0] q_cls [QDEPTH];
   logic             q_sp  [QDEPTH];
   int               q_count = 0;
   bit               q_suspended = 1'b0;

   job_event_type step_events[$];
   job_event_type pending_events[$];
   stim_row_type  stim_rows[$];

   int error_count = 0;
   int n_requests = 0;
   int n_dispatched = 0;
   int n_flushed = 0;
   int n_rejected = 0;
   int n_full_hits = 0;
   int send_count = 0;
   bit sender_calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[class_ordered_command_queue_top] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void pop_head(input logic busy);
      int i;
      if (busy || q_count == 0) return;
      // ordinary commands wait behind a suspend, special jobs go through
      if (q_suspended && !q_sp[0]) return;
      step_events.push_back('{EV_DISPATCH, q_tag[0], q_sp[0], 1'b0});
      for (i = 1; i < q_count; i++) begin
         q_tag[i-1] = q_tag[i];
         q_cls[i-1] = q_cls[i];
         q_sp[i-1]  = q_sp[i];
      end
      q_count--;
   endfunction

   function automatic void queue_request(input logic [ACTION_BITS-1:0] act,
                                         input logic [TAG_W-1:0] tag,
                                         input logic [CLS_W-1:0] cls,
                                         input logic sp, input logic busy);
      int pos;
      int i;
      step_events.delete();
      case (act)
         ACT_ENQUEUE: begin
            if (q_count >= QDEPTH) begin
               step_events.push_back('{EV_REJECT, tag, sp, 1'b0});
               n_full_hits++;
            end else begin
               pos = 0;
               while (pos < q_count && q_cls[pos] >= cls) pos++;
               for (i = q_count; i > pos; i--) begin
                  q_tag[i] = q_tag[i-1];
                  q_cls[i] = q_cls[i-1];
                  q_sp[i]  = q_sp[i-1];
               end
               q_tag[pos] = tag;
               q_cls[pos] = cls;
               q_sp[pos]  = sp;
               q_count++;
            end
            pop_head(busy);
         end
         ACT_DISPATCH: pop_head(busy);
         ACT_FLUSH: begin
            for (i = 0; i < q_count; i++)
               step_events.push_back('{EV_FLUSHED, q_tag[i], q_sp[i], 1'b0});
            q_count = 0;
            q_suspended = 1'b0;
         end
         ACT_SUSPEND: q_suspended = 1'b1;
         ACT_RESUME: begin
            q_suspended = 1'b0;
            pop_head(busy);
         end
         default: ;
      endcase
      if (step_events.size() > 0) step_events[step_events.size()-1].is_last = 1'b1;
   endfunction

   task automatic send_request(input logic [ACTION_BITS-1:0] act,
                               input logic [TAG_W-1:0] tag,
                               input logic [CLS_W-1:0] cls,
                               input logic sp, input logic busy,
                               input bit typed, input int n_typed,
                               input job_event_type typed_rsp);
      int gap;
      logic [REQ_W-1:0] word;
      if (send_count % 25 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      send_count++;
      gap = sender_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word = '0;
      word[TAG_W-1:0] = tag;
      word[TAG_W +: CLS_W] = cls;
      word[TAG_W+CLS_W] = sp;
      word[TAG_W+CLS_W+1] = busy;
      req_tdata <= word;
      req_tuser <= act;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      queue_request(act, tag, cls, sp, busy);
      if (typed) begin
         if (n_typed == 1) pending_events.push_back(typed_rsp);
      end else begin
         foreach (step_events[i]) pending_events.push_back(step_events[i]);
      end
      if (act <= ACT_RESUME) n_requests++;
   endtask

   task automatic drain_events();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
   endtask

   function automatic stim_row_type plain_row(input logic [ACTION_BITS-1:0] act,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [CLS_W-1:0] cls,
                                              input logic sp, input logic busy,
                                              input int reps);
      stim_row_type r;
      r.act = act;
      r.tag = tag;
      r.cls = cls;
      r.sp = sp;
      r.busy = busy;
      r.reps = reps;
      r.typed = 1'b0;
      r.n_typed = 0;
      r.rsp = '{EV_DISPATCH, '0, 1'b0, 1'b0};
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [ACTION_BITS-1:0] act,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [CLS_W-1:0] cls,
                                              input logic sp, input logic busy,
                                              input int n, input logic [EVENT_BITS-1:0] ev,
                                              input logic [TAG_W-1:0] etag, input logic esp);
      stim_row_type r;
      r = plain_row(act, tag, cls, sp, busy, 1);
      r.typed = 1'b1;
      r.n_typed = n;
      r.rsp = '{ev, etag, esp, 1'b1};
      return r;
   endfunction

   // scoreboard on the response side
   always @(posedge clock) begin : rsp_check
      job_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         case (rsp_tuser)
            EV_DISPATCH: n_dispatched++;
            EV_FLUSHED:  n_flushed++;
            EV_REJECT:   n_rejected++;
            default: ;
         endcase
         if (pending_events.size() == 0) begin
            report_mismatch("transfer with nothing pending, tag",
                            int'(rsp_tdata[TAG_W-1:0]), 0);
         end else begin
            want = pending_events.pop_front();
            if (rsp_tuser !== want.ev)
               report_mismatch("event", int'(rsp_tuser), int'(want.ev));
            if (rsp_tdata[TAG_W-1:0] !== want.tag)
               report_mismatch("tag", int'(rsp_tdata[TAG_W-1:0]), int'(want.tag));
            if (rsp_tdata[TAG_W] !== want.sp)
               report_mismatch("special flag", int'(rsp_tdata[TAG_W]), int'(want.sp));
            if (rsp_tlast !== want.is_last)
               report_mismatch("tlast", int'(rsp_tlast), int'(want.is_last));
         end
      end
   end

   initial begin : rsp_stall
      int stall;
      int k;
      bit calm;
      k = 0;
      calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (k % 30 == 0) calm = ($urandom_range(0, 3) == 0);
         k++;
         stall = calm ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : stimulus
      int j;
      int busy_pct;
      int pick;
      logic [ACTION_BITS-1:0] act;
      logic [TAG_W-1:0] tag;
      logic [CLS_W-1:0] cls;
      logic sp;
      job_event_type none;
      none = '{EV_DISPATCH, '0, 1'b0, 1'b0};
      busy_pct = 0;

      // empty queue, lone jobs, suspend and resume, unused codes
      stim_rows.push_back(typed_row(ACT_DISPATCH, 8'h00, 3'd0, 1'b0, 1'b0, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(typed_row(ACT_FLUSH, 8'h00, 3'd0, 1'b0, 1'b0, 0,
                                    EV_FLUSHED, 8'h00, 1'b0));
      stim_rows.push_back(typed_row(ACT_ENQUEUE, 8'hff, 3'd7, 1'b0, 1'b1, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(typed_row(ACT_ENQUEUE, 8'h00, 3'd0, 1'b1, 1'b0, 1,
                                    EV_DISPATCH, 8'hff, 1'b0));
      stim_rows.push_back(typed_row(ACT_SUSPEND, 8'h00, 3'd0, 1'b0, 1'b0, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(typed_row(ACT_SUSPEND, 8'h00, 3'd0, 1'b0, 1'b0, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(plain_row(ACT_ENQUEUE, 8'h55, 3'd3, 1'b0, 1'b0, 1));
      // special job at the head passes the suspend
      stim_rows.push_back(typed_row(ACT_ENQUEUE, 8'haa, 3'd5, 1'b1, 1'b0, 1,
                                    EV_DISPATCH, 8'haa, 1'b1));
      stim_rows.push_back(plain_row(ACT_DISPATCH, 8'h00, 3'd0, 1'b0, 1'b0, 1));
      stim_rows.push_back(plain_row(ACT_RESUME, 8'h00, 3'd0, 1'b0, 1'b1, 1));
      stim_rows.push_back(typed_row(ACT_SPARE_A, 8'hff, 3'd7, 1'b1, 1'b0, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(typed_row(ACT_SPARE_B, 8'h00, 3'd0, 1'b0, 1'b1, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(typed_row(ACT_SPARE_C, 8'h5a, 3'd2, 1'b1, 1'b0, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(plain_row(ACT_RESUME, 8'h00, 3'd0, 1'b0, 1'b0, 1));
      // fill the queue while the unit is busy, then overrun it
      stim_rows.push_back(plain_row(ACT_ENQUEUE, 8'h10, 3'd2, 1'b0, 1'b1, QDEPTH - 1));
      stim_rows.push_back(typed_row(ACT_ENQUEUE, 8'hc3, 3'd7, 1'b1, 1'b1, 1,
                                    EV_REJECT, 8'hc3, 1'b1));
      stim_rows.push_back(plain_row(ACT_ENQUEUE, 8'h3c, 3'd0, 1'b0, 1'b0, 1));
      stim_rows.push_back(plain_row(ACT_FLUSH, 8'h00, 3'd0, 1'b0, 1'b0, 1));
      // flush also lifts a suspend
      stim_rows.push_back(typed_row(ACT_SUSPEND, 8'h00, 3'd0, 1'b0, 1'b0, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(typed_row(ACT_ENQUEUE, 8'h81, 3'd4, 1'b0, 1'b0, 0,
                                    EV_DISPATCH, 8'h00, 1'b0));
      stim_rows.push_back(plain_row(ACT_FLUSH, 8'h00, 3'd0, 1'b0, 1'b0, 1));
      stim_rows.push_back(typed_row(ACT_ENQUEUE, 8'h7e, 3'd1, 1'b1, 1'b0, 1,
                                    EV_DISPATCH, 8'h7e, 1'b1));
      stim_rows.push_back(plain_row(ACT_DISPATCH, 8'h00, 3'd0, 1'b0, 1'b1, 1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[r]) begin
         for (j = 0; j < stim_rows[r].reps; j++) begin
            tag = TAG_W'(int'(stim_rows[r].tag) + j);
            cls = CLS_W'(int'(stim_rows[r].cls) + j);
            sp = stim_rows[r].sp ^ j[0];
            send_request(stim_rows[r].act, tag, cls, sp, stim_rows[r].busy,
                         stim_rows[r].typed, stim_rows[r].n_typed, stim_rows[r].rsp);
         end
      end
      drain_events();

      // random traffic; busy level shifts in blocks so the queue fills and empties
      j = 0;
      while (j < 320) begin
         if (j % 40 == 0) busy_pct = $urandom_range(0, 3) * 30;
         if (j == 160) drain_events();
         pick = $urandom_range(0, 99);
         if (pick < 50) act = ACT_ENQUEUE;
         else if (pick < 68) act = ACT_DISPATCH;
         else if (pick < 73) act = ACT_FLUSH;
         else if (pick < 83) act = ACT_SUSPEND;
         else if (pick < 95) act = ACT_RESUME;
         else if (pick < 97) act = ACT_SPARE_A;
         else if (pick < 99) act = ACT_SPARE_B;
         else act = ACT_SPARE_C;
         tag = TAG_W'($urandom_range(0, 255));
         cls = CLS_W'($urandom_range(0, 7));
         sp = ($urandom_range(0, 9) < 3);
         send_request(act, tag, cls, sp, ($urandom_range(0, 99) < busy_pct),
                      1'b0, 0, none);
         if (act <= ACT_RESUME) j++;
      end

      drain_events();
      repeat (40) @(posedge clock);
      if (pending_events.size() != 0)
         report_mismatch("events never delivered", pending_events.size(), 0);
      $display("covered %0d requests, %0d full-queue rejects predicted", n_requests,
               n_full_hits);
      $display("responses seen: %0d dispatched, %0d flushed, %0d rejected",
               n_dispatched, n_flushed, n_rejected);
      if (error_count == 0) begin
         $display("[class_ordered_command_queue_top] OK");
      end else begin
         $display("[class_ordered_command_queue_top] ERROR");
      end
      $finish;
   end

endmodule
